// ===== rtl/fpsc_pkg.sv =====
// Shared constants and types for the FITS pixel to float32 scaler.
`default_nettype none
package fpsc_pkg;

  localparam int CFG_INDEX_W = 8;
  localparam int COUNT_W     = 27;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = 2;
  localparam int FRAME_W     = 76;

  localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_FORMAT = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCALE        = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET       = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_COUNT  = 8'd3;

  localparam logic [1:0] FMT_U8  = 2'd0;
  localparam logic [1:0] FMT_S16 = 2'd1;
  localparam logic [1:0] FMT_S32 = 2'd2;
  localparam logic [1:0] FMT_F32 = 2'd3;

  localparam logic [31:0] ONE_BITS  = 32'h3F80_0000;
  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
  localparam logic [30:0] INF_MAG   = 31'h7F80_0000;

  // One assembled pixel word on its way from the front to the back.
  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  fmt;
    logic        last;
  } item_t;

  // Converted pixel between the integer conversion and the fused stage.
  typedef struct packed {
    logic [31:0] pix;
    logic        last;
  } conv_t;

  // Static arithmetic settings handed to the back.
  typedef struct packed {
    logic [31:0] scale;
    logic [31:0] offset;
    logic        bypass;
  } fcfg_t;

endpackage
`default_nettype wire

// ===== rtl/fpsc_queue.sv =====
// Short queue of assembled pixel words between the front and the back.
`default_nettype none
module fpsc_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire fpsc_pkg::item_t push_item,
  input  wire logic           pop,
  output logic                full,
  output logic                valid,
  output fpsc_pkg::item_t     head
);

  fpsc_pkg::item_t mem [fpsc_pkg::QDEPTH];
  logic [fpsc_pkg::QPTR_W-1:0] wr_ptr;
  logic [fpsc_pkg::QPTR_W-1:0] rd_ptr;
  logic [fpsc_pkg::QPTR_W:0]   level;

  assign full  = (level == (fpsc_pkg::QPTR_W+1)'(fpsc_pkg::QDEPTH));
  assign valid = (level != '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fpsc_front.sv =====
// Front: configuration registers, byte assembly and pixel counting.
`default_nettype none
module fpsc_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [7:0]                        s_tdata,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [fpsc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [31:0]                       cfg_data,
  input  wire logic                              q_full,
  output logic                                   q_push,
  output fpsc_pkg::item_t                        q_item,
  output fpsc_pkg::fcfg_t                        fcfg
);

  logic [1:0]                    fmt;
  logic [31:0]                   scale;
  logic [31:0]                   offset;
  logic [fpsc_pkg::COUNT_W-1:0]  count;
  logic [23:0]                   gather;
  logic [1:0]                    pos;
  logic [fpsc_pkg::COUNT_W-1:0]  remaining;
  logic                          done;
  logic                          take;
  logic                          complete;

  assign done      = (remaining == '0);
  assign s_tready  = done || !q_full;
  assign cfg_ready = 1'b1;
  assign take      = s_tvalid && s_tready && !done;

  always_comb begin
    unique case (fmt)
      fpsc_pkg::FMT_U8:  complete = 1'b1;
      fpsc_pkg::FMT_S16: complete = (pos == 2'd1);
      default:           complete = (pos == 2'd3);
    endcase
  end

  assign q_push      = take && complete;
  assign q_item.word = {gather, s_tdata};
  assign q_item.fmt  = fmt;
  assign q_item.last = (remaining == fpsc_pkg::COUNT_W'(1));

  assign fcfg.scale  = scale;
  assign fcfg.offset = offset;
  assign fcfg.bypass = (scale == fpsc_pkg::ONE_BITS) && (offset[30:0] == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt       <= fpsc_pkg::FMT_S16;
      scale     <= fpsc_pkg::ONE_BITS;
      offset    <= '0;
      count     <= '0;
      gather    <= '0;
      pos       <= '0;
      remaining <= '0;
    end else if (cfg_valid && (cfg_index <= fpsc_pkg::CFG_PIXEL_COUNT)) begin
      // Any register write restarts the image.
      gather    <= '0;
      pos       <= '0;
      remaining <= count;
      unique case (cfg_index)
        fpsc_pkg::CFG_PIXEL_FORMAT: fmt    <= cfg_data[1:0];
        fpsc_pkg::CFG_SCALE:        scale  <= cfg_data;
        fpsc_pkg::CFG_OFFSET:       offset <= cfg_data;
        default: begin
          count     <= cfg_data[fpsc_pkg::COUNT_W-1:0];
          remaining <= cfg_data[fpsc_pkg::COUNT_W-1:0];
        end
      endcase
    end else if (take) begin
      if (complete) begin
        gather    <= '0;
        pos       <= '0;
        remaining <= remaining - 1'b1;
      end else begin
        gather <= {gather[15:0], s_tdata};
        pos    <= pos + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fpsc_convert.sv =====
// Back, first part: integer pixels to float32, rounding to nearest even; float32 pixels pass through.
`default_nettype none
module fpsc_convert (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire fpsc_pkg::item_t in_item,
  output logic                 out_valid,
  output fpsc_pkg::conv_t      out_data
);

  // Stage 1: magnitude and the coarse part of the normalising shift.
  logic        c1_v;
  logic [31:0] c1_mag;
  logic [1:0]  c1_sh;
  logic        c1_neg, c1_flt, c1_zero, c1_last;
  logic [31:0] c1_word;

  logic [31:0] mag, m1, m2;
  logic        neg, step16, step8;
  logic [15:0] mag16;

  always_comb begin
    mag16 = in_item.word[15] ? (~in_item.word[15:0] + 16'd1) : in_item.word[15:0];
    unique case (in_item.fmt)
      fpsc_pkg::FMT_U8: begin
        neg = 1'b0;
        mag = {24'd0, in_item.word[7:0]};
      end
      fpsc_pkg::FMT_S16: begin
        neg = in_item.word[15];
        mag = {16'd0, mag16};
      end
      default: begin
        neg = in_item.word[31];
        mag = in_item.word[31] ? (~in_item.word + 32'd1) : in_item.word;
      end
    endcase
    step16 = (mag[31:16] == '0);
    m1     = step16 ? {mag[15:0], 16'd0} : mag;
    step8  = (m1[31:24] == '0);
    m2     = step8 ? {m1[23:0], 8'd0} : m1;
  end

  // Stage 2: fine part of the shift.
  logic        c2_v;
  logic [31:0] c2_n;
  logic [4:0]  c2_sh;
  logic        c2_neg, c2_flt, c2_zero, c2_last;
  logic [31:0] c2_word;

  logic [31:0] n4, n2, n1;
  logic        step4, step2, step1;

  always_comb begin
    step4 = (c1_mag[31:28] == '0);
    n4    = step4 ? {c1_mag[27:0], 4'd0} : c1_mag;
    step2 = (n4[31:30] == '0);
    n2    = step2 ? {n4[29:0], 2'd0} : n4;
    step1 = !n2[31];
    n1    = step1 ? {n2[30:0], 1'b0} : n2;
  end

  // Stage 3: round to 24 bits and pack.
  logic [7:0]  field_m1;
  logic        up;
  logic [24:0] mant;
  logic [30:0] packed_mag;
  logic [31:0] pix;

  always_comb begin
    field_m1   = 8'd157 - {3'd0, c2_sh};
    up         = c2_n[7] && ((c2_n[6:0] != '0) || c2_n[8]);
    mant       = {1'b0, c2_n[31:8]} + {24'd0, up};
    packed_mag = {field_m1, 23'd0} + {6'd0, mant};
    if (c2_flt) begin
      pix = c2_word;
    end else if (c2_zero) begin
      pix = '0;
    end else begin
      pix = {c2_neg, packed_mag};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_v      <= 1'b0;
      c2_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      c1_v      <= in_valid;
      c2_v      <= c1_v;
      out_valid <= c2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_mag  <= m2;
      c1_sh   <= {step16, step8};
      c1_neg  <= neg;
      c1_flt  <= (in_item.fmt == fpsc_pkg::FMT_F32);
      c1_zero <= (mag == '0);
      c1_last <= in_item.last;
      c1_word <= in_item.word;

      c2_n    <= n1;
      c2_sh   <= {c1_sh, step4, step2, step1};
      c2_neg  <= c1_neg;
      c2_flt  <= c1_flt;
      c2_zero <= c1_zero;
      c2_last <= c1_last;
      c2_word <= c1_word;

      out_data.pix  <= pix;
      out_data.last <= c2_last;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fpsc_fma.sv =====
// Back, second part: fused float32 pixel * scale + offset, rounded once.
`default_nettype none
module fpsc_fma (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire fpsc_pkg::conv_t in_data,
  input  wire fpsc_pkg::fcfg_t fcfg,
  output logic                 out_valid,
  output logic [31:0]          out_bits,
  output logic                 out_last
);

  localparam int FW = fpsc_pkg::FRAME_W;

  // Values that ride along unchanged behind the arithmetic.
  typedef struct packed {
    logic [31:0] pix;
    logic        last;
    logic        spec;
    logic [31:0] spec_bits;
  } carry_t;

  function automatic logic [4:0] lzc24(input logic [23:0] m);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (m[i]) begin
        n = 5'(23 - i);
      end
    end
    return n;
  endfunction

  // ---------------- stage F1: unpack, specials, normalise a and b
  logic [31:0] a, b, c;
  logic        a_nan, b_nan, c_nan, a_inf, b_inf, c_inf, a_zero, b_zero, c_zero;
  logic        ps;
  logic [23:0] ma, mb;
  logic [4:0]  lza, lzb;
  carry_t      k0;

  always_comb begin
    a      = in_data.pix;
    b      = fcfg.scale;
    c      = fcfg.offset;
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    c_nan  = (c[30:23] == 8'hFF) && (c[22:0] != '0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    c_inf  = (c[30:23] == 8'hFF) && (c[22:0] == '0);
    a_zero = (a[30:0] == '0);
    b_zero = (b[30:0] == '0);
    c_zero = (c[30:0] == '0);
    ps     = a[31] ^ b[31];
    ma     = {a[30:23] != '0, a[22:0]};
    mb     = {b[30:23] != '0, b[22:0]};
    lza    = lzc24(ma);
    lzb    = lzc24(mb);

    k0.pix       = a;
    k0.last      = in_data.last;
    k0.spec      = 1'b1;
    k0.spec_bits = fpsc_pkg::QNAN_BITS;
    if (a_nan || b_nan || c_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
      k0.spec_bits = fpsc_pkg::QNAN_BITS;
    end else if (a_inf || b_inf) begin
      if (c_inf && (c[31] != ps)) begin
        k0.spec_bits = fpsc_pkg::QNAN_BITS;
      end else begin
        k0.spec_bits = {ps, fpsc_pkg::INF_MAG};
      end
    end else if (c_inf) begin
      k0.spec_bits = c;
    end else if (a_zero || b_zero) begin
      k0.spec_bits = c_zero ? {ps & c[31], 31'd0} : c;
    end else begin
      k0.spec = 1'b0;
    end
  end

  logic               f1_v;
  carry_t             f1_k;
  logic [23:0]        f1_ma, f1_mb, f1_mc;
  logic signed [9:0]  f1_ea, f1_eb;
  logic [7:0]         f1_ec;
  logic               f1_ps, f1_sc;

  // ---------------- stage F2: product and alignment distance
  logic signed [11:0] cpos_w, fexp_w;

  always_comb begin
    cpos_w = $signed({4'd0, f1_ec}) - $signed({{2{f1_ea[9]}}, f1_ea})
           - $signed({{2{f1_eb[9]}}, f1_eb}) + 12'sd152;
    fexp_w = $signed({{2{f1_ea[9]}}, f1_ea}) + $signed({{2{f1_eb[9]}}, f1_eb}) - 12'sd302;
    if (f1_mc == '0) begin
      cpos_w = 12'sd1;
    end
  end

  logic               f2_v;
  carry_t             f2_k;
  logic [47:0]        f2_pm;
  logic [23:0]        f2_mc;
  logic signed [11:0] f2_cpos, f2_fexp;
  logic               f2_ps, f2_sc;

  // ---------------- stage F3: place both addends in one frame
  // Frame bit 0 only ever holds a sticky bit.
  logic [FW-1:0]      pf, cf;
  logic signed [11:0] rs;
  logic signed [11:0] fx;
  logic [23:0]        cbody;
  logic               cstk;

  always_comb begin
    rs    = 12'sd1 - f2_cpos;
    fx    = f2_fexp;
    cbody = '0;
    cstk  = 1'b0;
    if (f2_cpos > 12'sd51) begin
      // The product lies far below the offset: it only marks inexactness.
      // The offset sits lower in the frame than its true place, so the
      // frame exponent moves up by the difference.
      cf = FW'(f2_mc) << 51;
      pf = FW'(1);
      fx = f2_fexp + f2_cpos - 12'sd51;
    end else if (f2_cpos >= 12'sd1) begin
      cf = FW'(f2_mc) << f2_cpos[5:0];
      pf = FW'(f2_pm) << 2;
    end else begin
      if (rs >= 12'sd24) begin
        cstk = (f2_mc != '0);
      end else begin
        cbody = f2_mc >> rs[4:0];
        cstk  = ((f2_mc & ((24'd1 << rs[4:0]) - 24'd1)) != '0);
      end
      cf = (FW'(cbody) << 1) | FW'(cstk);
      pf = FW'(f2_pm) << 2;
    end
  end

  logic               f3_v;
  carry_t             f3_k;
  logic [FW-1:0]      f3_pf, f3_cf;
  logic signed [11:0] f3_fexp;
  logic               f3_ps, f3_sc;

  // ---------------- stage F4: add or subtract magnitudes
  logic [FW:0]   dpc;
  logic [FW-1:0] sum;
  logic          sgn;

  always_comb begin
    dpc = {1'b0, f3_pf} - {1'b0, f3_cf};
    if (f3_ps == f3_sc) begin
      sum = f3_pf + f3_cf;
      sgn = f3_ps;
    end else if (!dpc[FW]) begin
      sum = dpc[FW-1:0];
      sgn = f3_ps;
    end else begin
      sum = f3_cf - f3_pf;
      sgn = f3_sc;
    end
  end

  logic               f4_v;
  carry_t             f4_k;
  logic [FW-1:0]      f4_s;
  logic signed [11:0] f4_fexp;
  logic               f4_sgn;

  // ---------------- stage N1: nonzero flags per byte of the sum
  logic [79:0] s_pad;
  logic [9:0]  grp;

  always_comb begin
    s_pad = {4'd0, f4_s};
    for (int i = 0; i < 10; i++) begin
      grp[i] = (s_pad[i*8 +: 8] != '0);
    end
  end

  logic               n1_v;
  carry_t             n1_k;
  logic [FW-1:0]      n1_s;
  logic [9:0]         n1_grp;
  logic signed [11:0] n1_fexp;
  logic               n1_sgn;

  // ---------------- stage N2: leading one and the rounding position
  logic [79:0]        n1_pad;
  logic [3:0]         gi;
  logic [7:0]         gbyte;
  logic [2:0]         bi;
  logic signed [11:0] top, rsh_a, rsh_b;

  always_comb begin
    n1_pad = {4'd0, n1_s};
    gi     = '0;
    for (int i = 0; i < 10; i++) begin
      if (n1_grp[i]) begin
        gi = 4'(i);
      end
    end
    gbyte = n1_pad[{gi, 3'd0} +: 8];
    bi    = '0;
    for (int i = 0; i < 8; i++) begin
      if (gbyte[i]) begin
        bi = 3'(i);
      end
    end
    top   = $signed({5'd0, gi, bi});
    rsh_a = top - 12'sd23;
    rsh_b = -12'sd149 - n1_fexp;
  end

  logic               n2_v;
  carry_t             n2_k;
  logic [FW-1:0]      n2_s;
  logic               n2_zero;
  logic signed [11:0] n2_r, n2_fexp;
  logic               n2_sgn;

  // ---------------- stage N3: shift to 24 bits with guard and sticky
  logic signed [11:0] eb, nr;
  logic [FW-1:0]      shl, shr, smask;
  logic [23:0]        m;
  logic               g, st;
  logic [6:0]         rm1;

  always_comb begin
    eb    = n2_r + n2_fexp + 12'sd149;
    nr    = -n2_r;
    rm1   = n2_r[6:0] - 7'd1;
    shl   = n2_s << nr[4:0];
    shr   = n2_s >> n2_r[6:0];
    smask = (FW'(1) << rm1) - FW'(1);
    if (n2_r <= 12'sd0) begin
      m  = shl[23:0];
      g  = 1'b0;
      st = 1'b0;
    end else if (n2_r > 12'sd76) begin
      m  = '0;
      g  = 1'b0;
      st = !n2_zero;
    end else begin
      m  = shr[23:0];
      g  = n2_s[rm1];
      st = ((n2_s & smask) != '0);
    end
  end

  logic         n3_v;
  carry_t       n3_k;
  logic [23:0]  n3_m;
  logic         n3_g, n3_st, n3_zero, n3_sgn;
  logic [9:0]   n3_eb;

  // ---------------- stage N4: round, pack, pick the result
  logic        up;
  logic [24:0] mr;
  logic [33:0] total;
  logic [31:0] res;

  always_comb begin
    up    = n3_g && (n3_st || n3_m[0]);
    mr    = {1'b0, n3_m} + {24'd0, up};
    total = {1'b0, n3_eb, 23'd0} + {9'd0, mr};
    if (n3_zero) begin
      res = '0;
    end else if (total >= {3'd0, fpsc_pkg::INF_MAG}) begin
      res = {n3_sgn, fpsc_pkg::INF_MAG};
    end else begin
      res = {n3_sgn, total[30:0]};
    end
    if (fcfg.bypass) begin
      res = n3_k.pix;
    end else if (n3_k.spec) begin
      res = n3_k.spec_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v      <= 1'b0;
      f2_v      <= 1'b0;
      f3_v      <= 1'b0;
      f4_v      <= 1'b0;
      n1_v      <= 1'b0;
      n2_v      <= 1'b0;
      n3_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      f1_v      <= in_valid;
      f2_v      <= f1_v;
      f3_v      <= f2_v;
      f4_v      <= f3_v;
      n1_v      <= f4_v;
      n2_v      <= n1_v;
      n3_v      <= n2_v;
      out_valid <= n3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_k  <= k0;
      f1_ma <= ma << lza;
      f1_mb <= mb << lzb;
      f1_mc <= {c[30:23] != '0, c[22:0]};
      f1_ea <= $signed({2'd0, (a[30:23] == '0) ? 8'd1 : a[30:23]}) - $signed({5'd0, lza});
      f1_eb <= $signed({2'd0, (b[30:23] == '0) ? 8'd1 : b[30:23]}) - $signed({5'd0, lzb});
      f1_ec <= (c[30:23] == '0) ? 8'd1 : c[30:23];
      f1_ps <= ps;
      f1_sc <= c[31];

      f2_k    <= f1_k;
      f2_pm   <= f1_ma * f1_mb;
      f2_mc   <= f1_mc;
      f2_cpos <= cpos_w;
      f2_fexp <= fexp_w;
      f2_ps   <= f1_ps;
      f2_sc   <= f1_sc;

      f3_k    <= f2_k;
      f3_pf   <= pf;
      f3_cf   <= cf;
      f3_fexp <= fx;
      f3_ps   <= f2_ps;
      f3_sc   <= f2_sc;

      f4_k    <= f3_k;
      f4_s    <= sum;
      f4_fexp <= f3_fexp;
      f4_sgn  <= sgn;

      n1_k    <= f4_k;
      n1_s    <= f4_s;
      n1_grp  <= grp;
      n1_fexp <= f4_fexp;
      n1_sgn  <= f4_sgn;

      n2_k    <= n1_k;
      n2_s    <= n1_s;
      n2_zero <= (n1_grp == '0);
      n2_r    <= (rsh_a > rsh_b) ? rsh_a : rsh_b;
      n2_fexp <= n1_fexp;
      n2_sgn  <= n1_sgn;

      n3_k    <= n2_k;
      n3_m    <= m;
      n3_g    <= g;
      n3_st   <= st;
      n3_zero <= n2_zero;
      n3_sgn  <= n2_sgn;
      n3_eb   <= eb[9:0];

      out_bits <= res;
      out_last <= n3_k.last;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fits_pixel_to_float_scaler.sv =====
// After its final byte is accepted, a pixel passes through the queue, the converter stages and stages F1-F4, N1-N4.
// Throughput: one byte per cycle while the queue has room, so at most one pixel per cycle for 8-bit data.
// The byte rate is set by the front assembler; the back is a fully pipelined unit.
// A full output register stalls the back; the queue lets the front run on meanwhile.
// Reset (rst, synchronous) loads the register defaults and leaves nothing to convert.
// Top level of the FITS pixel to float32 scaler.
`default_nettype none
module fits_pixel_to_float_scaler (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Input stream; tdata: raw_byte [7:0].
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [7:0]                        s_tdata,
  // Output stream; tdata: pixel_bits [31:0]; tlast: last_pixel.
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [31:0]                            m_tdata,
  output logic                                   m_tlast,
  // Register write channel.
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [fpsc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [31:0]                       cfg_data
);

  // The front assembles big-endian pixels and pushes one request per pixel
  // into a short queue. The back pops a request whenever its pipeline moves.
  logic            q_push, q_full, q_valid, q_pop;
  fpsc_pkg::item_t q_item, q_head;
  fpsc_pkg::fcfg_t fcfg;
  logic            cv_valid;
  fpsc_pkg::conv_t cv_data;
  logic            en;

  // The whole back advances together whenever the output register is free
  // or being emptied in this cycle.
  assign en    = !m_tvalid || m_tready;
  assign q_pop = en && q_valid;

  fpsc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_item),
    .fcfg      (fcfg)
  );

  fpsc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head)
  );

  fpsc_convert u_convert (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (q_valid),
    .in_item   (q_head),
    .out_valid (cv_valid),
    .out_data  (cv_data)
  );

  fpsc_fma u_fma (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cv_valid),
    .in_data   (cv_data),
    .fcfg      (fcfg),
    .out_valid (m_tvalid),
    .out_bits  (m_tdata),
    .out_last  (m_tlast)
  );

  // The front never pushes a request into a full queue.
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("request pushed into a full queue");

  // The front only holds off the stream when the queue is full.
  assert property (@(posedge clk) disable iff (rst) !s_tready |-> q_full)
    else $error("input stalled while the queue has room");

endmodule
`default_nettype wire
